### hw/rtl/fqs_pkg.sv
// Shared constants, codes, types and helper functions for the searchable key FIFO.
`default_nettype none

package fqs_pkg;

  localparam int QueueDepth = 16;
  localparam int AddrW      = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);
  localparam int KeyW       = 32;
  localparam int PosW       = 4;
  localparam int CountW     = 5;
  localparam int OutBits    = KeyW + PosW + CountW + KeyW + KeyW;
  localparam int OutDataW   = ((OutBits + 7) / 8) * 8;

  typedef enum logic [1:0] {
    CMD_ENQ    = 2'd0,
    CMD_DEQ    = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_FETCH,
    S_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic do_enq;
    logic do_deq;
    logic do_clear;
    logic srch_step;
    logic load_front;
    logic res_load;
  } dp_ctrl_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    cmd_e cmd;
    logic empty;
    logic single;
    logic hit;
    logic exhausted;
  } dp_stat_t;

  function automatic logic [AddrW-1:0] next_slot(input logic [AddrW-1:0] idx);
    logic [AddrW-1:0] res;
    if (idx == AddrW'(QueueDepth - 1)) begin
      res = '0;
    end else begin
      res = idx + AddrW'(1);
    end
    return res;
  endfunction

  // Ring address of an offset from a base slot; the base is below the depth, the offset at most the depth.
  function automatic logic [AddrW-1:0] wrap_add(input logic [AddrW-1:0] base,
                                                input logic [CntW-1:0]  off);
    logic [AddrW:0] sum;
    sum = {1'b0, base} + (AddrW+1)'(off);
    if (sum >= (AddrW+1)'(QueueDepth)) begin
      sum = sum - (AddrW+1)'(QueueDepth);
    end
    return sum[AddrW-1:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/fqs_ctrl.sv
// Control state machine that sequences each command through the datapath.
`default_nettype none

module fqs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire fqs_pkg::dp_stat_t stat_i,
  output fqs_pkg::dp_ctrl_t      ctrl_o
);

  fqs_pkg::state_e state_q, state_d;
  logic            out_vld_q, out_vld_d;
  logic            out_free;

  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      fqs_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = fqs_pkg::S_EXEC;
        end
      end
      fqs_pkg::S_EXEC: begin
        case (stat_i.cmd)
          fqs_pkg::CMD_SEARCH: state_d = fqs_pkg::S_SEARCH;
          fqs_pkg::CMD_DEQ: begin
            if (!stat_i.empty && !stat_i.single) begin
              state_d = fqs_pkg::S_FETCH;
            end else begin
              state_d = fqs_pkg::S_DONE;
            end
          end
          default: state_d = fqs_pkg::S_DONE;
        endcase
      end
      fqs_pkg::S_SEARCH: begin
        if (stat_i.hit || stat_i.exhausted) begin
          state_d = fqs_pkg::S_DONE;
        end
      end
      fqs_pkg::S_FETCH: state_d = fqs_pkg::S_DONE;
      fqs_pkg::S_DONE: begin
        if (out_free) begin
          state_d = fqs_pkg::S_IDLE;
        end
      end
      default: state_d = fqs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      fqs_pkg::S_IDLE: begin
        in_ready_o       = 1'b1;
        ctrl_o.load_item = in_valid_i;
      end
      fqs_pkg::S_EXEC: begin
        ctrl_o.do_enq   = (stat_i.cmd == fqs_pkg::CMD_ENQ);
        ctrl_o.do_deq   = (stat_i.cmd == fqs_pkg::CMD_DEQ);
        ctrl_o.do_clear = (stat_i.cmd == fqs_pkg::CMD_CLEAR);
      end
      fqs_pkg::S_SEARCH: ctrl_o.srch_step  = 1'b1;
      fqs_pkg::S_FETCH:  ctrl_o.load_front = 1'b1;
      fqs_pkg::S_DONE:   ctrl_o.res_load   = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (ctrl_o.res_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fqs_pkg::S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fqs_dpath.sv
// Datapath: key ring memory, indices, count, search pipeline and result register.
`default_nettype none

module fqs_dpath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [1:0]                        cmd_i,
  input  wire logic [fqs_pkg::KeyW-1:0]          key_i,
  input  wire fqs_pkg::dp_ctrl_t                 ctrl_i,
  output fqs_pkg::dp_stat_t                      stat_o,
  output logic [1:0]                             res_status_o,
  output logic [fqs_pkg::OutDataW-1:0]           res_data_o
);

  logic [fqs_pkg::KeyW-1:0]  mem_q [fqs_pkg::QueueDepth];
  logic [fqs_pkg::KeyW-1:0]  rdata_q;
  logic [fqs_pkg::AddrW-1:0] rd_addr;

  logic [fqs_pkg::AddrW-1:0] rd_idx_q, rd_idx_d;
  logic [fqs_pkg::AddrW-1:0] wr_idx_q, wr_idx_d;
  logic [fqs_pkg::CntW-1:0]  count_q, count_d;

  fqs_pkg::cmd_e             cmd_q;
  logic [fqs_pkg::KeyW-1:0]  key_q;
  fqs_pkg::status_e          status_q;
  logic [fqs_pkg::KeyW-1:0]  removed_q;
  logic [fqs_pkg::CntW-1:0]  pos_q;
  logic [fqs_pkg::KeyW-1:0]  front_q;
  logic [fqs_pkg::KeyW-1:0]  back_q;

  logic [fqs_pkg::CntW-1:0]  srch_q;
  logic [fqs_pkg::CntW-1:0]  cmp_pos_q;
  logic                      cmp_vld_q;

  logic [1:0]                   res_status_q;
  logic [fqs_pkg::OutDataW-1:0] res_data_q;

  logic full, empty, hit, exhausted;
  logic [fqs_pkg::KeyW-1:0] front_out, back_out;

  assign full      = (count_q == fqs_pkg::CntW'(fqs_pkg::QueueDepth));
  assign empty     = (count_q == '0);
  assign hit       = cmp_vld_q && (rdata_q == key_q);
  assign exhausted = !cmp_vld_q && (srch_q >= count_q);

  assign stat_o.cmd       = cmd_q;
  assign stat_o.empty     = empty;
  assign stat_o.single    = (count_q == fqs_pkg::CntW'(1));
  assign stat_o.hit       = hit;
  assign stat_o.exhausted = exhausted;

  // During a search the port walks from the front; otherwise it looks one
  // slot past the front so a dequeue can refill the front register.
  assign rd_addr = ctrl_i.srch_step ? fqs_pkg::wrap_add(rd_idx_q, srch_q)
                                    : fqs_pkg::next_slot(rd_idx_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.do_enq && !full) begin
      mem_q[wr_idx_q] <= key_q;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_comb begin
    rd_idx_d = rd_idx_q;
    wr_idx_d = wr_idx_q;
    count_d  = count_q;
    if (ctrl_i.do_clear) begin
      rd_idx_d = '0;
      wr_idx_d = '0;
      count_d  = '0;
    end else if (ctrl_i.do_enq && !full) begin
      wr_idx_d = fqs_pkg::next_slot(wr_idx_q);
      count_d  = count_q + fqs_pkg::CntW'(1);
    end else if (ctrl_i.do_deq && !empty) begin
      rd_idx_d = fqs_pkg::next_slot(rd_idx_q);
      count_d  = count_q - fqs_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      wr_idx_q  <= '0;
      count_q   <= '0;
      srch_q    <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      rd_idx_q <= rd_idx_d;
      wr_idx_q <= wr_idx_d;
      count_q  <= count_d;
      if (ctrl_i.load_item) begin
        srch_q    <= '0;
        cmp_vld_q <= 1'b0;
      end else if (ctrl_i.srch_step) begin
        cmp_vld_q <= (srch_q < count_q);
        if (srch_q < count_q) begin
          srch_q <= srch_q + fqs_pkg::CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_item) begin
      cmd_q     <= fqs_pkg::cmd_e'(cmd_i);
      key_q     <= key_i;
      status_q  <= fqs_pkg::STAT_OK;
      removed_q <= '0;
      pos_q     <= '0;
    end
    if (ctrl_i.srch_step) begin
      cmp_pos_q <= srch_q;
      if (hit) begin
        pos_q <= cmp_pos_q;
      end else if (exhausted) begin
        status_q <= fqs_pkg::STAT_NOT_FOUND;
      end
    end
    if (ctrl_i.do_enq) begin
      if (full) begin
        status_q <= fqs_pkg::STAT_FULL;
      end else begin
        back_q <= key_q;
        if (empty) begin
          front_q <= key_q;
        end
      end
    end
    if (ctrl_i.do_deq) begin
      if (empty) begin
        status_q <= fqs_pkg::STAT_EMPTY;
      end else begin
        removed_q <= front_q;
      end
    end
    if (ctrl_i.load_front) begin
      front_q <= rdata_q;
    end
    if (ctrl_i.res_load) begin
      res_status_q <= status_q;
      res_data_q   <= {(fqs_pkg::OutDataW - fqs_pkg::OutBits)'(0), back_out, front_out,
                       fqs_pkg::CountW'(count_q), fqs_pkg::PosW'(pos_q), removed_q};
    end
  end

  assign front_out = empty ? '0 : front_q;
  assign back_out  = empty ? '0 : back_q;

  assign res_status_o = res_status_q;
  assign res_data_o   = res_data_q;

endmodule

`default_nettype wire

### hw/rtl/fifo_queue_with_search.sv
// Top level of the bounded signed-key FIFO with front-to-back linear search.
// Sequence: enqueue, clear and a dequeue that fails or empties the queue pass through the
// execute and done states; a dequeue that leaves keys behind adds a fetch state to refill
// the front key, and a search walks the held keys from the front in the search state until
// one matches or every held key has been compared, since the key memory has one read port.
// Flow: one command at a time; the next input is taken only once the result has
// entered the output register.
// Reset (rst_ni, asynchronous, active low) empties the queue; the key memory is not cleared.
`default_nettype none

module fifo_queue_with_search (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [fqs_pkg::KeyW-1:0]        s_axis_tdata,  // key_in
  input  wire logic [1:0]                      s_axis_tuser,  // command
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // key_out, match_position, entry_count, front_key, back_key, zero fill
  output logic [fqs_pkg::OutDataW-1:0]         m_axis_tdata,
  output logic [1:0]                           m_axis_tuser   // status
);

  fqs_pkg::dp_ctrl_t ctrl;
  fqs_pkg::dp_stat_t stat;

  // The controller holds the state and the output valid flag and decides the sequence of
  // each command; the key storage, indices, count and result register live in the datapath.
  fqs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  fqs_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (s_axis_tuser),
    .key_i        (s_axis_tdata),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .res_status_o (m_axis_tuser),
    .res_data_o   (m_axis_tdata)
  );

endmodule

`default_nettype wire

### hw/rtl/fqs_checker.sv
// Port-level checker for the searchable key FIFO and its bind to the top level.
`default_nettype none

module fqs_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      s_axis_tvalid,
  input wire logic                      s_axis_tready,
  input wire logic [fqs_pkg::KeyW-1:0]  s_axis_tdata,
  input wire logic [1:0]                s_axis_tuser,
  input wire logic                      m_axis_tvalid,
  input wire logic                      m_axis_tready,
  input wire logic [fqs_pkg::OutDataW-1:0] m_axis_tdata,
  input wire logic [1:0]                m_axis_tuser
);

  localparam int CntLo = fqs_pkg::KeyW + fqs_pkg::PosW;
  localparam int FrLo  = CntLo + fqs_pkg::CountW;
  localparam int BkLo  = FrLo + fqs_pkg::KeyW;

  logic [fqs_pkg::CountW-1:0] cnt;
  logic                       unused_in;

  assign cnt       = m_axis_tdata[FrLo-1:CntLo];
  assign unused_in = ^{s_axis_tdata, s_axis_tuser};

  // One command is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a command is in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt <= fqs_pkg::CountW'(fqs_pkg::QueueDepth))
    else $error("entry count beyond depth");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == fqs_pkg::STAT_EMPTY |->
      cnt == '0 && m_axis_tdata[fqs_pkg::KeyW-1:0] == '0)
    else $error("empty status with keys held or a removed key");

  a_empty_keys_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && cnt == '0 |->
      m_axis_tdata[BkLo-1:FrLo] == '0 && m_axis_tdata[BkLo+fqs_pkg::KeyW-1:BkLo] == '0)
    else $error("front or back key nonzero on empty queue");

endmodule

bind fifo_queue_with_search fqs_checker u_fqs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

### sim/queue_result_checker.sv
// Checker for the searchable key FIFO: predicts each command's result and compares transfers.
`timescale 1ns / 1ps

module queue_result_checker
  import fqs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [KeyW-1:0]     s_tdata_i,
  input  logic [1:0]          s_tuser_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  input  logic [1:0]          m_tuser_i,
  output int                  pending_o,
  output int                  errors_o
);

  // Bit positions of the result fields in m_tdata, lowest first.
  localparam int PosLsb   = KeyW;
  localparam int CountLsb = PosLsb + PosW;
  localparam int FrontLsb = CountLsb + CountW;
  localparam int BackLsb  = FrontLsb + KeyW;
  localparam int FillLsb  = BackLsb + KeyW;

  typedef struct packed {
    status_e           status;
    logic [KeyW-1:0]   removed_key;
    logic [PosW-1:0]   match_pos;
    logic [CountW-1:0] key_count;
    logic [KeyW-1:0]   front_key;
    logic [KeyW-1:0]   back_key;
  } queue_result_t;

  // Keys currently held, oldest first.
  logic [KeyW-1:0] held_keys[$];
  queue_result_t   awaited_results[$];

  initial begin
    pending_o = 0;
    errors_o  = 0;
  end

  // Applies one command to the held keys and returns the result it should produce.
  function automatic queue_result_t apply_command(input cmd_e cmd, input logic [KeyW-1:0] key);
    queue_result_t res;
    res = '0;
    res.status = STAT_OK;
    case (cmd)
      CMD_ENQ: begin
        if (held_keys.size() >= QueueDepth) begin
          res.status = STAT_FULL;
        end else begin
          held_keys.push_back(key);
        end
      end
      CMD_DEQ: begin
        if (held_keys.size() == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.removed_key = held_keys.pop_front();
        end
      end
      CMD_SEARCH: begin
        res.status = STAT_NOT_FOUND;
        for (int i = 0; i < held_keys.size(); i++) begin
          if (held_keys[i] == key) begin
            res.status    = STAT_OK;
            res.match_pos = PosW'(i);
            break;
          end
        end
      end
      default: begin
        held_keys.delete();
      end
    endcase
    res.key_count = CountW'(held_keys.size());
    if (held_keys.size() != 0) begin
      res.front_key = held_keys[0];
      res.back_key  = held_keys[held_keys.size() - 1];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [KeyW-1:0] got,
                                 input logic [KeyW-1:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    errors_o++;
  endtask

  task automatic check_result(input queue_result_t want);
    if (m_tuser_i != want.status)
      report_mismatch("status", KeyW'(m_tuser_i), KeyW'(want.status));
    if (m_tdata_i[KeyW-1:0] != want.removed_key)
      report_mismatch("key_out", m_tdata_i[KeyW-1:0], want.removed_key);
    if (m_tdata_i[PosLsb +: PosW] != want.match_pos)
      report_mismatch("match_position", KeyW'(m_tdata_i[PosLsb +: PosW]), KeyW'(want.match_pos));
    if (m_tdata_i[CountLsb +: CountW] != want.key_count)
      report_mismatch("entry_count", KeyW'(m_tdata_i[CountLsb +: CountW]),
                      KeyW'(want.key_count));
    if (m_tdata_i[FrontLsb +: KeyW] != want.front_key)
      report_mismatch("front_key", m_tdata_i[FrontLsb +: KeyW], want.front_key);
    if (m_tdata_i[BackLsb +: KeyW] != want.back_key)
      report_mismatch("back_key", m_tdata_i[BackLsb +: KeyW], want.back_key);
    if (m_tdata_i[OutDataW-1:FillLsb] != '0)
      report_mismatch("zero fill", KeyW'(m_tdata_i[OutDataW-1:FillLsb]), '0);
  endtask

  // The result transfer is handled before the command transfer of the same edge,
  // since it always belongs to an earlier command.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_keys.delete();
      awaited_results.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with nothing awaited", m_tdata_i[KeyW-1:0], '0);
        end else begin
          check_result(awaited_results.pop_front());
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        awaited_results.push_back(apply_command(cmd_e'(s_tuser_i), s_tdata_i));
      end
    end
    pending_o = awaited_results.size();
  end

endmodule

### sim/testbench.sv
// Top of the FIFO-with-search regression: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import fqs_pkg::*;

  localparam int RandomItems = 1800;
  // The limit bounds the whole run and leaves a wide margin, stalls included.
  localparam int CycleLimit  = 400000;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [KeyW-1:0]     s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  int              pending_results;
  int              error_count;
  int              cycle_count;
  // While set, neither the command sender nor the result receiver pauses.
  bit              steady_flow;
  logic [KeyW-1:0] key_pool[16];

  fifo_queue_with_search uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  queue_result_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tuser_i  (m_axis_tuser),
    .pending_o  (pending_results),
    .errors_o   (error_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // A hung handshake or a result that never shows up ends the run here.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("fifo_queue_with_search regression: fail");
      $finish;
    end
  end

  // The result side stalls on about a quarter of the cycles, except in the steady stretch.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= steady_flow || ($urandom_range(99) >= 26);
    end
  end

  // Sends one command and returns at the falling edge after its transfer, with
  // valid still high so that a back-to-back command follows without a gap.
  task automatic send_command(input cmd_e cmd, input logic [KeyW-1:0] key);
    if (!steady_flow && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Holds the command side until every result that is owed has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
  endtask

  // Mostly keys from a small pool, so searches hit, plus fully random keys.
  function automatic logic [KeyW-1:0] pick_key();
    logic [KeyW-1:0] key;
    if ($urandom_range(99) < 65) begin
      key = key_pool[$urandom_range(15)];
    end else begin
      key = $urandom;
    end
    return key;
  endfunction

  initial begin
    int   roll;
    int   enq_ceiling;
    cmd_e cmd;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_ENQ;
    steady_flow   = 1'b0;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    key_pool[4] = 32'h0000_0001;
    for (int i = 5; i < 16; i++) key_pool[i] = $urandom;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: empty-queue cases, extreme keys, a full queue, a wrap of
    // the ring, and a clear.
    send_command(CMD_DEQ, 32'h1234_5678);
    send_command(CMD_SEARCH, 32'h0000_0000);
    send_command(CMD_ENQ, 32'h8000_0000);
    send_command(CMD_ENQ, 32'h7FFF_FFFF);
    send_command(CMD_ENQ, 32'h0000_0000);
    send_command(CMD_ENQ, 32'hFFFF_FFFF);
    send_command(CMD_SEARCH, 32'h7FFF_FFFF);
    send_command(CMD_SEARCH, 32'h5555_AAAA);
    for (int i = 4; i < QueueDepth; i++) send_command(CMD_ENQ, 32'hA000_0000 + i);
    send_command(CMD_ENQ, 32'hDEAD_BEEF);
    send_command(CMD_SEARCH, 32'hA000_0000 + QueueDepth - 1);
    send_command(CMD_DEQ, '0);
    send_command(CMD_ENQ, 32'h0F0F_F0F0);
    send_command(CMD_CLEAR, 32'hFFFF_FFFF);
    send_command(CMD_DEQ, '0);
    drain_results();
    @(negedge clk_i);

    // Random part in phases that lean toward filling, draining, or neither, so
    // the queue swings between empty and full and the ring pointers wrap often.
    for (int n = 0; n < RandomItems; n++) begin
      steady_flow = (n >= 600 && n < 900);
      if (n % 300 == 299) begin
        drain_results();
        @(negedge clk_i);
      end
      case ((n / 150) % 3)
        0:       enq_ceiling = 82;
        1:       enq_ceiling = 45;
        default: enq_ceiling = 64;
      endcase
      roll = $urandom_range(99);
      if (roll < 2) begin
        cmd = CMD_CLEAR;
      end else if (roll < 27) begin
        cmd = CMD_SEARCH;
      end else if (roll < enq_ceiling) begin
        cmd = CMD_ENQ;
      end else begin
        cmd = CMD_DEQ;
      end
      send_command(cmd, pick_key());
    end
    steady_flow = 1'b0;

    drain_results();
    repeat (25) @(negedge clk_i);
    if (error_count == 0 && pending_results == 0) begin
      $display("fifo_queue_with_search regression: pass");
    end else begin
      $display("fifo_queue_with_search regression: fail");
    end
    $finish;
  end

endmodule
